@@ rtl/htfc_pkg.sv @@
// shared types, constants and functions for the humidity/temperature frame checker
// no dependencies; htfc_front, htfc_queue, htfc_back and the top unit import this package
`default_nettype none

package htfc_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [14:0] TEMP_SCALE   = 15'd17500;
    localparam logic [13:0] HUMID_SCALE  = 14'd12500;
    localparam logic [15:0] TEMP_OFFSET  = 16'd4500;
    localparam logic [15:0] HUMID_OFFSET = 16'd600;
    localparam logic [15:0] HUMID_UPPER  = 16'd10600;
    localparam logic [13:0] HUMID_MAX    = 14'd10000;

    // byte slot within the six-byte reply
    typedef enum logic [2:0] {
        POS_TEMP_HI   = 3'd0,
        POS_TEMP_LO   = 3'd1,
        POS_TEMP_CRC  = 3'd2,
        POS_HUMID_HI  = 3'd3,
        POS_HUMID_LO  = 3'd4,
        POS_HUMID_CRC = 3'd5,
        POS_IDLE      = 3'd6
    } pos_t;

    // one checked frame waiting for conversion
    typedef struct packed {
        logic        ok;
        logic [15:0] raw_temp;
        logic [15:0] raw_humid;
    } htfc_job_t;

    typedef struct packed {
        logic      valid;
        htfc_job_t job;
    } htfc_xfer_t;

    // crc-8, msb first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

    // floor(x / 65535) for quotients below 65536, no divider needed
    function automatic logic [15:0] div_by_65535(input logic [31:0] x);
        logic [32:0] s;
        s = {1'b0, x} + {17'd0, x[31:16]} + 33'd1;
        return s[31:16];
    endfunction

endpackage

`default_nettype wire

@@ rtl/htfc_byte_if.sv @@
// valid/ready channel carrying one received reply byte
// no dependencies
`default_nettype none

interface htfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_start;

    modport source (output valid, frame_byte, frame_start, input ready);
    modport sink   (input valid, frame_byte, frame_start, output ready);
endinterface

`default_nettype wire

@@ rtl/htfc_result_if.sv @@
// valid/ready channel carrying one converted reading
// no dependencies
`default_nettype none

interface htfc_result_if;
    logic               valid;
    logic               ready;
    logic               crc_ok;
    logic signed [14:0] temperature_centi;
    logic        [13:0] humidity_centi;

    modport source (output valid, crc_ok, temperature_centi, humidity_centi, input ready);
    modport sink   (input valid, crc_ok, temperature_centi, humidity_centi, output ready);
endinterface

`default_nettype wire

@@ rtl/htfc_front.sv @@
// front end: byte tracking, crc checks, word assembly, job push
// depends on htfc_pkg and htfc_byte_if
`default_nettype none

module htfc_front
    import htfc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    htfc_byte_if.sink   byte_ch,
    input  wire logic   queue_full,
    output htfc_xfer_t  push
);

    pos_t        pos_reg, pos_next, pos_eff;
    logic [7:0]  crc_reg, crc_next, crc_eff;
    logic        temp_good_reg, temp_good_next;
    logic [15:0] raw_temp_reg, raw_temp_next;
    logic [15:0] raw_humid_reg, raw_humid_next;
    logic        accept;

    assign byte_ch.ready = !queue_full;
    assign accept        = byte_ch.valid && byte_ch.ready;

    // frame_start forces slot zero with a fresh crc
    assign pos_eff = byte_ch.frame_start ? POS_TEMP_HI : pos_reg;
    assign crc_eff = byte_ch.frame_start ? CRC_INIT : crc_reg;

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            case (pos_eff)
                POS_TEMP_HI:   pos_next = POS_TEMP_LO;
                POS_TEMP_LO:   pos_next = POS_TEMP_CRC;
                POS_TEMP_CRC:  pos_next = POS_HUMID_HI;
                POS_HUMID_HI:  pos_next = POS_HUMID_LO;
                POS_HUMID_LO:  pos_next = POS_HUMID_CRC;
                POS_HUMID_CRC: pos_next = POS_IDLE;
                default:       pos_next = pos_reg;
            endcase
        end
    end

    always_comb
    begin
        crc_next       = crc_reg;
        temp_good_next = temp_good_reg;
        raw_temp_next  = raw_temp_reg;
        raw_humid_next = raw_humid_reg;
        push.valid     = 1'b0;
        push.job.ok        = temp_good_reg && (crc_eff == byte_ch.frame_byte);
        push.job.raw_temp  = raw_temp_reg;
        push.job.raw_humid = raw_humid_reg;
        if (accept)
        begin
            case (pos_eff)
                POS_TEMP_HI:
                begin
                    crc_next      = crc8_update(crc_eff, byte_ch.frame_byte);
                    raw_temp_next = {byte_ch.frame_byte, 8'd0};
                end
                POS_TEMP_LO:
                begin
                    crc_next      = crc8_update(crc_eff, byte_ch.frame_byte);
                    raw_temp_next = {raw_temp_reg[15:8], byte_ch.frame_byte};
                end
                POS_TEMP_CRC:
                begin
                    temp_good_next = (crc_eff == byte_ch.frame_byte);
                    crc_next       = CRC_INIT;
                end
                POS_HUMID_HI:
                begin
                    crc_next       = crc8_update(crc_eff, byte_ch.frame_byte);
                    raw_humid_next = {byte_ch.frame_byte, 8'd0};
                end
                POS_HUMID_LO:
                begin
                    crc_next       = crc8_update(crc_eff, byte_ch.frame_byte);
                    raw_humid_next = {raw_humid_reg[15:8], byte_ch.frame_byte};
                end
                POS_HUMID_CRC:
                begin
                    crc_next   = CRC_INIT;
                    push.valid = 1'b1;
                end
                default:
                begin
                    crc_next = crc_reg;
                end
            endcase
        end
    end

    // both raw words are complete before the humidity crc byte arrives
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_IDLE;
            crc_reg       <= CRC_INIT;
            temp_good_reg <= 1'b0;
            raw_temp_reg  <= 16'd0;
            raw_humid_reg <= 16'd0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_good_reg <= temp_good_next;
            raw_temp_reg  <= raw_temp_next;
            raw_humid_reg <= raw_humid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/htfc_queue.sv @@
// small job queue between front end and conversion back end
// depends on htfc_pkg
`default_nettype none

module htfc_queue
    import htfc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  htfc_xfer_t push,
    output logic       full,
    output htfc_xfer_t pop,
    input  wire logic  pop_ready
);

    htfc_job_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop.valid = (count_reg != '0);
    assign pop.job   = slot_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop.valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/htfc_back.sv @@
// back end: scale multiply, divide by 65535, offset and clamp, held values
// depends on htfc_pkg and htfc_result_if
`default_nettype none

module htfc_back
    import htfc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  htfc_xfer_t     pop,
    output logic           pop_ready,
    htfc_result_if.source  result_ch
);

    logic        mul_valid_reg;
    logic        mul_ok_reg;
    logic [30:0] prod_temp_reg;
    logic [29:0] prod_humid_reg;

    logic        out_valid_reg, out_valid_next;
    logic        out_ok_reg;
    logic [14:0] held_temp_reg;
    logic [13:0] held_humid_reg;

    logic        out_free, advance, take;
    logic [15:0] q_temp, q_humid, temp_diff;
    logic [14:0] temp_conv;
    logic [13:0] humid_conv;

    assign out_free  = !out_valid_reg || result_ch.ready;
    assign advance   = mul_valid_reg && out_free;
    assign pop_ready = !mul_valid_reg || advance;
    assign take      = pop.valid && pop_ready;

    // multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (pop_ready)
        begin
            mul_valid_reg <= pop.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mul_ok_reg     <= pop.job.ok;
            prod_temp_reg  <= 31'(pop.job.raw_temp) * 31'(TEMP_SCALE);
            prod_humid_reg <= 30'(pop.job.raw_humid) * 30'(HUMID_SCALE);
        end
    end

    // divide, offset and clamp
    always_comb
    begin
        q_temp    = div_by_65535({1'b0, prod_temp_reg});
        q_humid   = div_by_65535({2'b00, prod_humid_reg});
        temp_diff = q_temp - TEMP_OFFSET;
        temp_conv = temp_diff[14:0];
        if (q_humid < HUMID_OFFSET)
        begin
            humid_conv = '0;
        end
        else if (q_humid > HUMID_UPPER)
        begin
            humid_conv = HUMID_MAX;
        end
        else
        begin
            humid_conv = 14'(q_humid - HUMID_OFFSET);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // output register doubles as the last good reading
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_ok_reg     <= 1'b0;
            held_temp_reg  <= '0;
            held_humid_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                out_ok_reg <= mul_ok_reg;
                if (mul_ok_reg)
                begin
                    held_temp_reg  <= temp_conv;
                    held_humid_reg <= humid_conv;
                end
            end
        end
    end

    assign result_ch.valid             = out_valid_reg;
    assign result_ch.crc_ok            = out_ok_reg;
    assign result_ch.temperature_centi = held_temp_reg;
    assign result_ch.humidity_centi    = held_humid_reg;

endmodule

`default_nettype wire

@@ rtl/humidity_temp_frame_checker_unit.sv @@
// channel   | dir  | payload                                         | result per
// byte_ch   | in   | frame_byte[7:0], frame_start                    | -
// result_ch | out  | crc_ok, temperature_centi[14:0] s, humidity[13:0] | 6th byte
//
// one byte per cycle; bytes never wait on conversion, only on a full job queue
// a reading passes through the queue, the multiply register and the divide/output register after its sixth byte
// the back end retires one frame per cycle while result_ch is ready, far above the one-per-six-bytes demand
// reset: idle waiting for frame_start, crc 0xff, held readings 0, queue empty
// a stalled result holds the output register; the queue absorbs up to 4 frames
// depends on htfc_pkg, htfc_byte_if, htfc_result_if, htfc_front, htfc_queue, htfc_back
`default_nettype none

module humidity_temp_frame_checker_unit
    import htfc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    htfc_byte_if.sink      byte_ch,
    htfc_result_if.source  result_ch
);

    htfc_xfer_t push;
    htfc_xfer_t pop;
    logic       queue_full;
    logic       pop_ready;

    // byte tracking and crc checks; pushes one job per complete frame
    htfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .queue_full (queue_full),
        .push       (push)
    );

    // decouples byte intake from result stalls
    htfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (queue_full),
        .pop       (pop),
        .pop_ready (pop_ready)
    );

    // fixed-point conversion and held readings
    htfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .pop_ready (pop_ready),
        .result_ch (result_ch)
    );

    // the front end must never try to push a frame into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !queue_full)
        else $error("frame job pushed into full queue");

    // humidity clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> (result_ch.humidity_centi <= HUMID_MAX))
        else $error("humidity above clamp");

    // temperature conversion range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> ((result_ch.temperature_centi >= -15'sd4500)
                          && (result_ch.temperature_centi <= 15'sd13000)))
        else $error("temperature out of range");

endmodule

`default_nettype wire
